// ----- sv/qrs_pkg.sv -----
// qrs_pkg: types and codes shared by the quadratic root solver
// no dependencies; compile first

package qrs_pkg;

  typedef enum logic [2:0] {
    ST_NONE,
    ST_ALL,
    ST_LINEAR,
    ST_DZERO,
    ST_DNEG,
    ST_DPOS,
    ST_UNSUP,
    ST_DIVZERO
  } status_t;

  localparam logic [1:0] DEG_CONST = 2'd0;
  localparam logic [1:0] DEG_LIN   = 2'd1;
  localparam logic [1:0] DEG_QUAD  = 2'd2;
  localparam logic [1:0] DEG_CUBIC = 2'd3;

  typedef struct packed {
    logic [1:0]   degree;
    logic [31:0]  coef_a;
    logic [31:0]  coef_b;
    logic [31:0]  coef_c;
  } in_t;

  typedef struct packed {
    status_t      status;
    logic         root_index;
    logic [31:0]  root_real;
    logic [31:0]  root_imag;
    logic         saturated;
    logic         last;
  } out_t;

  // control carried down the front half of the pipe
  typedef struct packed {
    logic                vld;
    status_t             status;
    logic signed [31:0]  a;
    logic signed [31:0]  b;
  } ctl_t;

  // square root stage: radicand bits still to consume, partial remainder and root
  typedef struct packed {
    ctl_t         c;
    logic [63:0]  v;
    logic [33:0]  rem;
    logic [31:0]  root;
  } sq_t;

  // one divider lane: partial remainder, dividend bits shifting out / quotient in
  typedef struct packed {
    logic [32:0]  r;
    logic [31:0]  w;
    logic         big;
    logic         neg;
  } lane_t;

  typedef struct packed {
    logic         vld;
    status_t      status;
    lane_t        x;
    lane_t        y;
    logic [32:0]  dm;
  } dv_t;

endpackage

// ----- sv/quadratic_root_solver_unit.sv -----
// quadratic_root_solver_unit: pipelined solver for degree 0..2 fixed-point polynomials
// depends on qrs_pkg
//
//  channel | valid        | stall        | payload
//  --------+--------------+--------------+---------------------------
//  item    | item_valid   | item_stall   | item   (qrs_pkg::in_t)
//  result  | result_valid | result_stall | result (qrs_pkg::out_t)
//
// path from item transfer to first result: two multiply/classify stages, a
// 16-stage square root (two root bits per stage), numerator and range check, a
// 16-stage restoring divider (two quotient bits per stage) and the result buffer.
// the pipe takes an item every cycle while not stalled; the single result port holds
// the pipe while an item's second root waits, so an item with two roots stalls the input.
// synchronous reset clears valid bits and the result buffer count only.
// stall on the result side freezes the whole pipe; nothing is dropped or repeated.

module quadratic_root_solver_unit import qrs_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  output logic  item_stall,
  input  in_t   item,
  output logic  result_valid,
  input  logic  result_stall,
  output out_t  result
);

  localparam int NW     = 34 + FRAC_BITS;
  localparam int STAGES = 16;

  function automatic sq_t sq_iter(sq_t s);
    logic [35:0] t;
    logic [35:0] trial;
    sq_t         o;
    o = s;
    for (int k = 0; k < 2; k++) begin
      t     = {o.rem, o.v[63:62]};
      trial = {2'b00, o.root, 2'b01};
      if (t >= trial) begin
        o.rem  = 34'(t - trial);
        o.root = {o.root[30:0], 1'b1};
      end else begin
        o.rem  = t[33:0];
        o.root = {o.root[30:0], 1'b0};
      end
      o.v = {o.v[61:0], 2'b00};
    end
    return o;
  endfunction

  function automatic lane_t dv_iter(lane_t l, logic [32:0] dm);
    logic [33:0] t;
    lane_t       o;
    o = l;
    for (int k = 0; k < 2; k++) begin
      t = {o.r, o.w[31]};
      if (t >= {1'b0, dm}) begin
        o.r = 33'(t - {1'b0, dm});
        o.w = {o.w[30:0], 1'b1};
      end else begin
        o.r = t[32:0];
        o.w = {o.w[30:0], 1'b0};
      end
    end
    return o;
  endfunction

  // sign and clamp a quotient magnitude; returns {value, saturated}
  function automatic logic [32:0] fix_q(lane_t l);
    logic [32:0] res;
    if (!l.neg) begin
      if (l.big || l.w[31]) res = {32'h7fff_ffff, 1'b1};
      else                  res = {l.w, 1'b0};
    end else begin
      if (l.big || (l.w > 32'h8000_0000)) res = {32'h8000_0000, 1'b1};
      else                                res = {32'(32'd0 - l.w), 1'b0};
    end
    return res;
  endfunction

  logic adv;
  logic xfer;
  logic [1:0] cnt;
  out_t slot0, slot1;

  // stage 1: products
  ctl_t               c1;
  logic [63:0]        bb;
  logic signed [63:0] ac;

  // square root pipe, entry 0 is the classify stage
  sq_t sq [STAGES+1];

  // numerator stage
  logic        fv;
  status_t     fst;
  logic [33:0] ux, uy;
  logic        nx_neg, ny_neg;
  logic [32:0] fdm;

  dv_t dv [STAGES+1];

  // combinational helpers
  status_t            st_in;
  logic [31:0]        mb;
  logic signed [65:0] e;
  status_t            st_q;
  ctl_t               c1q;
  logic [63:0]        mag;
  logic signed [34:0] nb, s2, nx, ny;
  logic [32:0]        am;
  logic [NW-1:0]      nxw, nyw;
  logic [32:0]        fx, fy;

  assign xfer         = result_valid && !result_stall;
  assign adv          = (cnt == 2'd0) || ((cnt == 2'd1) && !result_stall);
  assign item_stall   = !adv;
  assign result_valid = (cnt != 2'd0);
  assign result       = slot0;

  always_comb begin
    mb = item.coef_b[31] ? 32'(32'd0 - item.coef_b) : item.coef_b;
    if (item.degree == DEG_CONST)      st_in = (item.coef_a != 32'd0) ? ST_NONE : ST_ALL;
    else if (item.degree == DEG_CUBIC) st_in = ST_UNSUP;
    else if (item.coef_a == 32'd0)     st_in = ST_DIVZERO;
    else if (item.degree == DEG_LIN)   st_in = ST_LINEAR;
    else                               st_in = ST_DPOS;
  end

  always_comb begin
    // b*b/4 - a*c, keeping the two dropped bits for the zero test
    e   = $signed({4'b0000, bb[63:2]}) - 66'(ac);
    mag = e[65] ? 64'(-e) : 64'(e);
    st_q = c1.status;
    if (c1.status == ST_DPOS) begin
      if ((e == 66'sd0) && (bb[1:0] == 2'b00)) st_q = ST_DZERO;
      else if (e[65])                          st_q = ST_DNEG;
    end
    c1q        = c1;
    c1q.status = st_q;
  end

  always_comb begin
    nb = -35'(sq[STAGES].c.b);
    s2 = $signed({2'b00, sq[STAGES].root, 1'b0});
    nx = nb;
    ny = s2;
    if (sq[STAGES].c.status == ST_DPOS) begin
      nx = nb - s2;
      ny = nb + s2;
    end
    am = sq[STAGES].c.a[31] ? 33'(-34'(sq[STAGES].c.a)) : 33'(sq[STAGES].c.a);
  end

  always_comb begin
    nxw = NW'(ux) << FRAC_BITS;
    nyw = NW'(uy) << FRAC_BITS;
  end

  always_comb begin
    fx = fix_q(dv[STAGES].x);
    fy = fix_q(dv[STAGES].y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1.vld <= 1'b0;
      fv     <= 1'b0;
      for (int i = 0; i <= STAGES; i++) begin
        sq[i].c.vld <= 1'b0;
        dv[i].vld   <= 1'b0;
      end
    end else if (adv) begin
      c1.vld    <= item_valid;
      c1.status <= st_in;
      c1.a      <= $signed(item.coef_a);
      c1.b      <= $signed(item.coef_b);
      bb        <= 64'(mb) * 64'(mb);
      ac        <= 64'($signed(item.coef_a)) * 64'($signed(item.coef_c));

      sq[0].c    <= c1q;
      sq[0].v    <= mag;
      sq[0].rem  <= '0;
      sq[0].root <= '0;
      for (int i = 1; i <= STAGES; i++) sq[i] <= sq_iter(sq[i-1]);

      fv     <= sq[STAGES].c.vld;
      fst    <= sq[STAGES].c.status;
      ux     <= nx[34] ? 34'(-nx) : nx[33:0];
      uy     <= ny[34] ? 34'(-ny) : ny[33:0];
      nx_neg <= nx[34] ^ sq[STAGES].c.a[31];
      // the negative-discriminant lane holds +2S, the sign of the second imaginary part
      ny_neg <= ny[34] ^ sq[STAGES].c.a[31];
      fdm    <= (sq[STAGES].c.status == ST_LINEAR) ? am : {am[31:0], 1'b0};

      dv[0].vld    <= fv;
      dv[0].status <= fst;
      dv[0].dm     <= fdm;
      dv[0].x.r    <= 33'(nxw[NW-1:32]);
      dv[0].x.w    <= nxw[31:0];
      dv[0].x.big  <= 33'(nxw[NW-1:32]) >= fdm;
      dv[0].x.neg  <= nx_neg;
      dv[0].y.r    <= 33'(nyw[NW-1:32]);
      dv[0].y.w    <= nyw[31:0];
      dv[0].y.big  <= 33'(nyw[NW-1:32]) >= fdm;
      dv[0].y.neg  <= ny_neg;
      for (int i = 1; i <= STAGES; i++) begin
        dv[i].vld    <= dv[i-1].vld;
        dv[i].status <= dv[i-1].status;
        dv[i].dm     <= dv[i-1].dm;
        dv[i].x      <= dv_iter(dv[i-1].x, dv[i-1].dm);
        dv[i].y      <= dv_iter(dv[i-1].y, dv[i-1].dm);
      end
    end
  end

  // result buffer: up to two results of one item
  logic     two;
  out_t     r0, r1;
  lane_t    yn;
  logic [32:0] fyn;

  always_comb begin
    yn     = dv[STAGES].y;
    yn.neg = !dv[STAGES].y.neg;
    fyn    = fix_q(yn);
    two    = 1'b0;
    r0     = '0;
    r0.status = dv[STAGES].status;
    r0.last   = 1'b1;
    r1     = r0;
    r1.root_index = 1'b1;
    case (dv[STAGES].status)
      ST_LINEAR, ST_DZERO: begin
        r0.root_real = fx[32:1];
        r0.saturated = fx[0];
      end
      ST_DNEG: begin
        two          = 1'b1;
        r0.last      = 1'b0;
        r0.root_real = fx[32:1];
        r0.root_imag = fyn[32:1];
        r0.saturated = fx[0] | fyn[0];
        r1.root_real = fx[32:1];
        r1.root_imag = fy[32:1];
        r1.saturated = fx[0] | fy[0];
      end
      ST_DPOS: begin
        two          = 1'b1;
        r0.last      = 1'b0;
        r0.root_real = fx[32:1];
        r0.saturated = fx[0];
        r1.root_real = fy[32:1];
        r1.saturated = fy[0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (adv) begin
      if (dv[STAGES].vld) cnt <= two ? 2'd2 : 2'd1;
      else                cnt <= 2'd0;
    end else if (xfer) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      slot0 <= r0;
      slot1 <= r1;
    end else if (xfer) begin
      slot0 <= slot1;
    end
  end

endmodule
